### hw/rtl/pft_pkg.sv
// types and constants shared by the polygon fan triangulator modules
// no dependencies
package pft_pkg;

	localparam int FIELD_W = 24;
	localparam int TDATA_W = 3 * FIELD_W;

	localparam logic [FIELD_W-1:0] TRI_DEGREE = FIELD_W'(3);

	// output sequence positions within one triangle
	localparam logic [1:0] STEP_HDR   = 2'd0;
	localparam logic [1:0] STEP_FIRST = 2'd1;
	localparam logic [1:0] STEP_PREV  = 2'd2;
	localparam logic [1:0] STEP_CUR   = 2'd3;

	typedef struct packed {
		logic [FIELD_W-1:0] c;
		logic [FIELD_W-1:0] b;
		logic [FIELD_W-1:0] a;
	} corner_t;

	typedef struct packed {
		logic               rec;
		logic [FIELD_W-1:0] mat;
		corner_t            first;
		corner_t            prev;
		corner_t            cur;
	} tri_t;

endpackage

### hw/rtl/pft_track.sv
// polygon stream tracker: header/corner position, first and previous corner
// depends on pft_pkg
module pft_track (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  pft_pkg::corner_t cur,
	input  logic             emit_records,
	output logic             go,
	output pft_pkg::tri_t    tri_out
);

	logic                        expect_q;
	logic [pft_pkg::FIELD_W-1:0] left_q;
	logic [1:0]                  seen_q;
	logic                        skip_q;
	logic [pft_pkg::FIELD_W-1:0] mat_q;
	pft_pkg::corner_t            first_q;
	pft_pkg::corner_t            prev_q;

	logic [pft_pkg::FIELD_W-1:0] left_dec;

	assign left_dec = left_q - pft_pkg::FIELD_W'(1);
	assign go       = !expect_q && !skip_q && (seen_q == 2'd2);

	assign tri_out.rec   = emit_records;
	assign tri_out.mat   = mat_q;
	assign tri_out.first = first_q;
	assign tri_out.prev  = prev_q;
	assign tri_out.cur   = cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= 1'b1;
			left_q   <= '0;
			seen_q   <= 2'd0;
			skip_q   <= 1'b0;
			mat_q    <= '0;
		end else if (take) begin
			if (expect_q) begin
				left_q   <= cur.a;
				seen_q   <= 2'd0;
				mat_q    <= cur.b;
				skip_q   <= (cur.a < pft_pkg::TRI_DEGREE);
				expect_q <= (cur.a == '0);
			end else begin
				left_q <= left_dec;
				if (left_dec == '0) begin
					expect_q <= 1'b1;
					skip_q   <= 1'b0;
					seen_q   <= 2'd0;
				end else if (!skip_q && seen_q != 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

	// corner stores: written before read within a polygon
	always_ff @(posedge clk) begin
		if (take && !expect_q && !skip_q) begin
			if (seen_q == 2'd0) begin
				first_q <= cur;
			end else begin
				prev_q <= cur;
			end
		end
	end

endmodule

### hw/rtl/pft_emit.sv
// triangle buffer, output sequencer: one item per cycle into out reg unless stalled
// depends on pft_pkg
module pft_emit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  pft_pkg::tri_t               tri_in,
	output logic                        free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pft_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast
);

	pft_pkg::tri_t tri_s2;
	logic          vld_s2;
	logic [1:0]    step_s2;

	logic                        out_valid_q;
	logic [pft_pkg::TDATA_W-1:0] out_data_q;
	logic                        out_last_q;

	logic                        out_load;
	logic                        last_step;
	pft_pkg::corner_t            item;

	assign last_step = (step_s2 == pft_pkg::STEP_CUR);
	assign out_load  = vld_s2 && (!out_valid_q || m_tready);
	assign free      = !vld_s2 || (out_load && last_step);

	always_comb begin
		unique case (step_s2)
			pft_pkg::STEP_HDR: begin
				item.a = pft_pkg::TRI_DEGREE;
				item.b = tri_s2.mat;
				item.c = '0;
			end
			pft_pkg::STEP_FIRST: item = tri_s2.first;
			pft_pkg::STEP_PREV:  item = tri_s2.prev;
			default:             item = tri_s2.cur;
		endcase
		if (!tri_s2.rec) begin
			item.b = '0;
			item.c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			step_s2 <= pft_pkg::STEP_HDR;
		end else if (load) begin
			vld_s2  <= 1'b1;
			step_s2 <= tri_in.rec ? pft_pkg::STEP_HDR : pft_pkg::STEP_FIRST;
		end else if (out_load) begin
			if (last_step) begin
				vld_s2 <= 1'b0;
			end else begin
				step_s2 <= step_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tri_s2 <= tri_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= item;
			out_last_q <= last_step;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

### hw/rtl/polygon_fan_triangulator.sv
// Polygon fan triangulator. Input transactions are raw mesh words: a header
// (degree, material) followed by degree corners; polygons under three corners
// are dropped. From the third corner on each corner yields one fan triangle:
// four output transactions (header 3/material/0, first, previous, current
// corner) when emit_records is 1, or three position-only transactions when 0,
// tlast on the final one. The output register moves one transaction per
// cycle unless m_tready stalls it; a header or corner is taken only once
// the triangle buffer is free. All input fields are masked to INDEX_BITS.
// Words pass the input register, triangle buffer and output register.
// emit_records may only be written while the block is idle.
// depends on pft_pkg, pft_track, pft_emit
module polygon_fan_triangulator #(
	parameter int INDEX_BITS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pft_pkg::TDATA_W-1:0] s_tdata,  // word_a, word_b, word_c
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pft_pkg::TDATA_W-1:0] m_tdata,  // out_a, out_b, out_c
	output logic                        m_tlast,  // run_last
	input  logic                        emit_records_we,
	input  logic                        emit_records_wdata
);

	localparam int IW = (INDEX_BITS < pft_pkg::FIELD_W) ? INDEX_BITS : pft_pkg::FIELD_W;
	localparam logic [pft_pkg::FIELD_W-1:0] IDX_MASK =
		pft_pkg::FIELD_W'((33'd1 << IW) - 33'd1);

	logic             emit_q;
	logic             valid_s1;
	pft_pkg::corner_t word_s1;
	logic             take;
	logic             go;
	logic             free;
	pft_pkg::tri_t    tri_w;
	pft_pkg::corner_t in_word;

	assign in_word.a = s_tdata[pft_pkg::FIELD_W-1:0] & IDX_MASK;
	assign in_word.b = s_tdata[2*pft_pkg::FIELD_W-1:pft_pkg::FIELD_W] & IDX_MASK;
	assign in_word.c = s_tdata[3*pft_pkg::FIELD_W-1:2*pft_pkg::FIELD_W] & IDX_MASK;

	assign take     = valid_s1 && free;
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b1;
		end else if (emit_records_we) begin
			emit_q <= emit_records_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			word_s1 <= in_word;
		end
	end

	pft_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.cur          (word_s1),
		.emit_records (emit_q),
		.go           (go),
		.tri_out      (tri_w)
	);

	pft_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (take && go),
		.tri_in   (tri_w),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### hw/rtl/pft_checker.sv
// port-level checks for the polygon fan triangulator, bound to the top level
// depends on pft_pkg and polygon_fan_triangulator
module pft_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pft_pkg::TDATA_W-1:0] m_tdata,
	input logic                        m_tlast
);

	logic [1:0] run_cnt_q;

	// non-final transactions seen since the last final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_cnt_q <= 2'd0;
		end else if (m_tvalid && m_tready) begin
			if (m_tlast) begin
				run_cnt_q <= 2'd0;
			end else if (run_cnt_q != 2'd3) begin
				run_cnt_q <= run_cnt_q + 2'd1;
			end
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid straight after reset");

	a_run_dense: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a triangle");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> (m_tlast ? (run_cnt_q >= 2'd2) : (run_cnt_q <= 2'd2)))
		else $error("triangle with wrong transaction count");

endmodule

bind polygon_fan_triangulator pft_checker u_pft_checker (.*);
